// File: sv/esp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esp_pkg
// Shared types and constants of the encoder speed PID controller.
// ----------------------------------------------------------------------------
package esp_pkg;

  // one control tick
  typedef struct packed {
    logic [15:0] count_now;
    logic [15:0] count_before;
    logic        counting_down;
    logic [15:0] elapsed_ms;
    logic [7:0]  target_speed;
    logic [6:0]  last_command;
  } esp_in_t;

  // one result
  typedef struct packed {
    logic [6:0]  drive_command;
    logic [15:0] measured_speed;
    logic        held;
  } esp_out_t;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_PROP     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_INTEGRAL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_DERIV    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE_SPEED  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_MAX    = 3'd6;

  localparam logic [15:0] RST_GAIN_PROP     = 16'd77;
  localparam logic [15:0] RST_GAIN_INTEGRAL = 16'd179;
  localparam logic [15:0] RST_GAIN_DERIV    = 16'd1792;
  localparam logic [15:0] RST_SPEED_LIMIT   = 16'd550;
  localparam logic [15:0] RST_SETTLE_SPEED  = 16'd250;
  localparam logic [9:0]  RST_DEADBAND      = 10'd15;
  localparam logic [6:0]  RST_OUTPUT_MAX    = 7'd127;

  // serial divider
  localparam int DIVISOR_W = 16;
  localparam int LEN_W     = 6;
  localparam int K1000_W   = 10;   // bits of the 1000 ms numerator
  localparam int DMAG_W    = 32;   // |gain_deriv * error step|
  localparam int MAG2_W    = 36;   // 2 * |PID sum|
  localparam logic [K1000_W-1:0]   MS_PER_S = 10'd1000;
  localparam logic [DIVISOR_W-1:0] DIV_NINE = 16'd9;

  typedef struct packed {
    logic             start;
    logic [LEN_W-1:0] len;     // dividend bits, left aligned
  } esp_div_req_t;

  // serial multiplier
  localparam int MCAND_W   = 18;
  localparam int MPLIER_W  = 16;
  localparam int PROD_W    = 34;
  localparam int MUL_CNT_W = 5;
  localparam logic [MUL_CNT_W-1:0] MUL_STEPS = 5'd16;

endpackage

// File: sv/esp_sdiv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esp_sdiv
// Restoring divider, one quotient bit per cycle, unsigned.
// ----------------------------------------------------------------------------
module esp_sdiv #(
  parameter int DIV_W = 38
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  esp_pkg::esp_div_req_t          req,
  input  logic [DIV_W-1:0]               dividend,
  input  logic [esp_pkg::DIVISOR_W-1:0]  divisor,
  output logic [DIV_W-1:0]               quot,
  output logic                           done
);

  logic [DIV_W-1:0]              num_r;
  logic [esp_pkg::DIVISOR_W-1:0] rem_r, den_r, rem_nxt;
  logic [esp_pkg::LEN_W-1:0]     cnt_r;
  logic                          done_r;
  logic [esp_pkg::DIVISOR_W:0]   rem_sh, rem_dif;
  logic                          ge;

  always_comb begin
    rem_sh  = {rem_r, num_r[DIV_W-1]};
    rem_dif = rem_sh - {1'b0, den_r};
    ge      = (rem_sh >= {1'b0, den_r});
    // remainder stays below the divisor, so the top bit drops out
    rem_nxt = ge ? rem_dif[esp_pkg::DIVISOR_W-1:0] : rem_sh[esp_pkg::DIVISOR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (req.start) begin
      cnt_r  <= req.len;
      done_r <= 1'b0;
    end else if (cnt_r != '0) begin
      cnt_r  <= cnt_r - 1'b1;
      done_r <= (cnt_r == esp_pkg::LEN_W'(1));
    end else begin
      done_r <= 1'b0;
    end
  end

  // quotient bits shift in at the bottom as dividend bits leave the top
  always_ff @(posedge clk) begin
    if (req.start) begin
      num_r <= dividend;
      rem_r <= '0;
      den_r <= divisor;
    end else if (cnt_r != '0) begin
      num_r <= {num_r[DIV_W-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign quot = num_r;
  assign done = done_r;

endmodule

// File: sv/esp_smul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esp_smul
// Shift-add multiplier: signed multiplicand, unsigned multiplier, one
// multiplier bit per cycle.
// ----------------------------------------------------------------------------
module esp_smul (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [esp_pkg::MCAND_W-1:0]  mcand,
  input  logic [esp_pkg::MPLIER_W-1:0]        mplier,
  output logic signed [esp_pkg::PROD_W-1:0]   prod,
  output logic                                done
);

  logic signed [esp_pkg::PROD_W-1:0] acc_r, mc_r;
  logic [esp_pkg::MPLIER_W-1:0]      mp_r;
  logic [esp_pkg::MUL_CNT_W-1:0]     cnt_r;
  logic                              done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (start) begin
      cnt_r  <= esp_pkg::MUL_STEPS;
      done_r <= 1'b0;
    end else if (cnt_r != '0) begin
      cnt_r  <= cnt_r - 1'b1;
      done_r <= (cnt_r == esp_pkg::MUL_CNT_W'(1));
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
      mc_r  <= esp_pkg::PROD_W'(mcand);
      mp_r  <= mplier;
    end else if (cnt_r != '0) begin
      if (mp_r[0]) begin
        acc_r <= acc_r + mc_r;
      end
      mc_r <= mc_r <<< 1;
      mp_r <= mp_r >> 1;
    end
  end

  assign prod = acc_r;
  assign done = done_r;

endmodule

// File: sv/encoder_speed_pid_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// encoder_speed_pid_top
// Motor speed controller: encoder counts to rpm, deadband hold, Q8.8 PID.
// ----------------------------------------------------------------------------
// One beat on the in_ channel is one control tick; it yields exactly one beat
// on the out_ channel. The block works on one tick at a time: in_stall is high
// from the cycle after a beat is taken until its result sits in the output
// register. Results go through a shared bit-serial divider (one quotient bit a
// cycle) and a shift-add multiplier (one multiplier bit a cycle); a tick that
// the deadband hold applies to skips the PID multiplies and divides.
// The output register decouples the two sides: a new tick is taken while the
// previous result waits; if the receiver still stalls when the next result is
// ready, the sequencer waits and the stalled beat holds steady.
// Configuration writes on cfg_ take effect at once and belong in idle periods.
// Synchronous reset restores the register defaults, clears the integral and
// previous error, and drops out_valid. No clearing pass follows reset.
// ----------------------------------------------------------------------------
module encoder_speed_pid_top #(
  parameter int COUNTER_BITS   = 16,
  parameter int COUNTS_PER_REV = 1216
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  esp_pkg::esp_in_t                 in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output esp_pkg::esp_out_t                out_data,
  input  logic                             cfg_we,
  input  logic [esp_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [esp_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int CB     = COUNTER_BITS;
  localparam int NUM1_W = CB + 6;
  localparam int DIV_W  = (NUM1_W > esp_pkg::MAG2_W) ? NUM1_W : esp_pkg::MAG2_W;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_START = 4'd1;
  localparam logic [3:0] S_Q1    = 4'd2;
  localparam logic [3:0] S_Q2    = 4'd3;
  localparam logic [3:0] S_SPD   = 4'd4;
  localparam logic [3:0] S_ERR   = 4'd5;
  localparam logic [3:0] S_CHK   = 4'd6;
  localparam logic [3:0] S_MP    = 4'd7;
  localparam logic [3:0] S_MI    = 4'd8;
  localparam logic [3:0] S_MD    = 4'd9;
  localparam logic [3:0] S_DD    = 4'd10;
  localparam logic [3:0] S_SUM   = 4'd11;
  localparam logic [3:0] S_MAG   = 4'd12;
  localparam logic [3:0] S_DC    = 4'd13;
  localparam logic [3:0] S_DONE  = 4'd14;

  // configuration
  logic [15:0] gain_prop_r, gain_int_r, gain_deriv_r, speed_limit_r, settle_r;
  logic [9:0]  deadband_r;
  logic [6:0]  out_max_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_prop_r   <= esp_pkg::RST_GAIN_PROP;
      gain_int_r    <= esp_pkg::RST_GAIN_INTEGRAL;
      gain_deriv_r  <= esp_pkg::RST_GAIN_DERIV;
      speed_limit_r <= esp_pkg::RST_SPEED_LIMIT;
      settle_r      <= esp_pkg::RST_SETTLE_SPEED;
      deadband_r    <= esp_pkg::RST_DEADBAND;
      out_max_r     <= esp_pkg::RST_OUTPUT_MAX;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        esp_pkg::REG_GAIN_PROP:     gain_prop_r   <= cfg_wdata;
        esp_pkg::REG_GAIN_INTEGRAL: gain_int_r    <= cfg_wdata;
        esp_pkg::REG_GAIN_DERIV:    gain_deriv_r  <= cfg_wdata;
        esp_pkg::REG_SPEED_LIMIT:   speed_limit_r <= cfg_wdata;
        esp_pkg::REG_SETTLE_SPEED:  settle_r      <= cfg_wdata;
        esp_pkg::REG_DEADBAND:      deadband_r    <= cfg_wdata[9:0];
        esp_pkg::REG_OUTPUT_MAX:    out_max_r     <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  // control and controller state
  logic [3:0]         state_r, state_nxt;
  logic               out_valid_r;
  esp_pkg::esp_out_t  out_data_r;
  logic signed [31:0] integral_r;
  logic signed [15:0] prev_err_r;

  // per-tick payload
  logic [CB-1:0]      delta_r;
  logic [15:0]        ms_r;
  logic [10:0]        target_r;
  logic [6:0]         last_r;
  logic [16:0]        q1_r;
  logic [15:0]        speed_r;
  logic signed [15:0] err_r;
  logic signed [33:0] p_r, d_r;
  logic signed [31:0] i_r;
  logic               d_neg_r;
  logic signed [35:0] sum_r;
  logic [6:0]         res_cmd_r;
  logic               res_held_r;

  // arithmetic units
  esp_pkg::esp_div_req_t                   div_req;
  logic [DIV_W-1:0]                        div_dvd, div_quot;
  logic [esp_pkg::DIVISOR_W-1:0]           div_dvs;
  logic                                    div_done;
  logic                                    mul_start, mul_done;
  logic signed [esp_pkg::MCAND_W-1:0]      mul_mc;
  logic [esp_pkg::MPLIER_W-1:0]            mul_mp;
  logic signed [esp_pkg::PROD_W-1:0]       mul_prod;

  esp_sdiv #(.DIV_W(DIV_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .quot     (div_quot),
    .done     (div_done)
  );

  esp_smul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .mcand  (mul_mc),
    .mplier (mul_mp),
    .prod   (mul_prod),
    .done   (mul_done)
  );

  // encoder delta, wrap formula as in the original firmware (max - x + y)
  logic [CB-1:0] now_c, bef_c, delta;
  always_comb begin
    now_c = CB'(in_data.count_now);
    bef_c = CB'(in_data.count_before);
    if (in_data.counting_down) begin
      delta = (now_c < bef_c) ? (bef_c - now_c) : (~now_c + bef_c);
    end else begin
      delta = (now_c > bef_c) ? (now_c - bef_c) : (~bef_c + now_c);
    end
  end

  // combinational helpers
  logic [NUM1_W-1:0]  num1;
  logic signed [17:0] err_wide;
  logic [15:0]        abs_err;
  logic               hold;
  logic signed [16:0] err_step;
  logic signed [34:0] int_sum;
  logic signed [31:0] int_sat;
  logic [33:0]        dprod_mag;
  logic [35:0]        sum_mag, mag2;
  logic [DIV_W-9:0]   cmd_q;
  logic [6:0]         cmd_sat;

  always_comb begin
    num1     = (NUM1_W'(delta_r) << 6) - (NUM1_W'(delta_r) << 2);
    err_wide = $signed({7'b0, target_r}) - $signed({2'b0, speed_r});
    abs_err  = err_r[15] ? 16'(-err_r) : 16'(err_r);
    hold     = (speed_r > settle_r) && (abs_err < {6'b0, deadband_r});
    err_step = 17'(err_r) - 17'(prev_err_r);
    int_sum  = 35'(integral_r) + 35'(mul_prod);
    if (!int_sum[34] && (int_sum[33:31] != 3'b000)) begin
      int_sat = 32'sh7fffffff;
    end else if (int_sum[34] && (int_sum[33:31] != 3'b111)) begin
      int_sat = 32'sh80000000;
    end else begin
      int_sat = int_sum[31:0];
    end
    dprod_mag = mul_prod[33] ? 34'(-mul_prod) : 34'(mul_prod);
    sum_mag   = sum_r[35] ? 36'(-sum_r) : 36'(sum_r);
    mag2      = {sum_mag[34:0], 1'b0};
    cmd_q     = div_quot[DIV_W-1:8];
    cmd_sat   = (cmd_q > (DIV_W-8)'(out_max_r)) ? out_max_r : cmd_q[6:0];
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    div_req   = '0;
    div_dvd   = '0;
    div_dvs   = '0;
    mul_start = 1'b0;
    mul_mc    = '0;
    mul_mp    = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && !in_stall) state_nxt = S_START;
      end
      S_START: begin
        div_req.start = 1'b1;
        div_req.len   = esp_pkg::LEN_W'(NUM1_W);
        div_dvd       = DIV_W'(num1) << (DIV_W - NUM1_W);
        div_dvs       = 16'(COUNTS_PER_REV);
        state_nxt     = S_Q1;
      end
      S_Q1: begin
        if (div_done) begin
          div_req.start = 1'b1;
          div_req.len   = esp_pkg::LEN_W'(esp_pkg::K1000_W);
          div_dvd       = DIV_W'(esp_pkg::MS_PER_S) << (DIV_W - esp_pkg::K1000_W);
          div_dvs       = ms_r;
          state_nxt     = S_Q2;
        end
      end
      S_Q2: begin
        if (div_done) begin
          mul_start = 1'b1;
          mul_mc    = $signed({1'b0, q1_r});
          mul_mp    = 16'(div_quot[esp_pkg::K1000_W-1:0]);
          state_nxt = S_SPD;
        end
      end
      S_SPD: begin
        if (mul_done) state_nxt = S_ERR;
      end
      S_ERR: state_nxt = S_CHK;
      S_CHK: begin
        if (hold) begin
          state_nxt = S_DONE;
        end else begin
          mul_start = 1'b1;
          mul_mc    = 18'(err_r);
          mul_mp    = gain_prop_r;
          state_nxt = S_MP;
        end
      end
      S_MP: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_mc    = 18'(err_r);
          mul_mp    = gain_int_r;
          state_nxt = S_MI;
        end
      end
      S_MI: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_mc    = 18'(err_step);
          mul_mp    = gain_deriv_r;
          state_nxt = S_MD;
        end
      end
      S_MD: begin
        if (mul_done) begin
          div_req.start = 1'b1;
          div_req.len   = esp_pkg::LEN_W'(esp_pkg::DMAG_W);
          div_dvd       = DIV_W'(dprod_mag[esp_pkg::DMAG_W-1:0]) << (DIV_W - esp_pkg::DMAG_W);
          div_dvs       = ms_r;
          state_nxt     = S_DD;
        end
      end
      S_DD: begin
        if (div_done) state_nxt = S_SUM;
      end
      S_SUM: state_nxt = S_MAG;
      S_MAG: begin
        div_req.start = 1'b1;
        div_req.len   = esp_pkg::LEN_W'(esp_pkg::MAG2_W);
        div_dvd       = DIV_W'(mag2) << (DIV_W - esp_pkg::MAG2_W);
        div_dvs       = esp_pkg::DIV_NINE;
        state_nxt     = S_DC;
      end
      S_DC: begin
        if (div_done) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      integral_r  <= '0;
      prev_err_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_DONE && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == S_DC && div_done) begin
        integral_r <= i_r;
        prev_err_r <= err_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid && !in_stall) begin
      delta_r  <= delta;
      ms_r     <= (in_data.elapsed_ms == 16'd0) ? 16'd1 : in_data.elapsed_ms;
      target_r <= 11'((({4'b0, in_data.target_speed} << 3) + {4'b0, in_data.target_speed}) >> 1);
      last_r   <= in_data.last_command;
    end
    if (state_r == S_Q1 && div_done) begin
      // anything past 16 bits is over any limit once scaled by a nonzero factor
      q1_r <= (div_quot[DIV_W-1:16] != '0) ? 17'h10000 : {1'b0, div_quot[15:0]};
    end
    if (state_r == S_SPD && mul_done) begin
      speed_r <= (mul_prod[26:0] > 27'(speed_limit_r)) ? 16'd0 : mul_prod[15:0];
    end
    if (state_r == S_ERR) begin
      if (err_wide < -18'sd32768) begin
        err_r <= 16'sh8000;
      end else if (err_wide > 18'sd32767) begin
        err_r <= 16'sh7fff;
      end else begin
        err_r <= err_wide[15:0];
      end
    end
    if (state_r == S_CHK && hold) begin
      res_cmd_r  <= last_r;
      res_held_r <= 1'b1;
    end
    if (state_r == S_MP && mul_done) p_r <= mul_prod;
    if (state_r == S_MI && mul_done) i_r <= int_sat;
    if (state_r == S_MD && mul_done) d_neg_r <= mul_prod[33];
    if (state_r == S_DD && div_done) begin
      // truncate toward zero: divide the magnitude, then restore the sign
      d_r <= d_neg_r ? -$signed({2'b0, div_quot[esp_pkg::DMAG_W-1:0]})
                     :  $signed({2'b0, div_quot[esp_pkg::DMAG_W-1:0]});
    end
    if (state_r == S_SUM) sum_r <= 36'(p_r) + 36'(d_r) + 36'(i_r);
    if (state_r == S_DC && div_done) begin
      res_cmd_r  <= cmd_sat;
      res_held_r <= 1'b0;
    end
    if (state_r == S_DONE && (!out_valid_r || !out_stall)) begin
      out_data_r.drive_command  <= res_cmd_r;
      out_data_r.measured_speed <= speed_r;
      out_data_r.held           <= res_held_r;
    end
  end

  assign in_stall  = (state_r != S_IDLE) || !rst_n;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: sv/esp_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esp_check
// Port-level checks of the speed controller, bound to the top level.
// ----------------------------------------------------------------------------
module esp_check (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input esp_pkg::esp_out_t out_data
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  // one tick at a time: the input side closes right after a beat is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a tick is in flight");

  // a fresh result only appears at the end of a tick in flight
  a_out_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a tick in flight");

  // hold needs a speed above the settle speed, so never zero
  a_held_speed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.held |-> out_data.measured_speed != 16'd0)
    else $error("held result with zero speed");

endmodule

bind encoder_speed_pid_top esp_check u_esp_check (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// File: sim/encoder_speed_pid_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// encoder_speed_pid_top_tb
// Self-checking bench for the encoder speed PID controller. A directed table
// covers count wrap, direction, zero and extreme elapsed times, overspeed and
// the deadband hold. Random ticks follow under several register settings,
// with bursty input and a patterned output stall. Every result beat is checked
// against its table entry or a local model of the speed and PID arithmetic.
// ----------------------------------------------------------------------------
module encoder_speed_pid_top_tb;

  localparam int HALF_PERIOD       = 4;
  localparam int RESET_CYCLES      = 6;
  localparam int N_DIR             = 21;
  localparam int N_SETTINGS        = 8;
  localparam int TICKS_PER_SETTING = 150;
  localparam int SETTLE_CYCLES     = 16;
  localparam int IDLE_LIMIT        = 4000;

  localparam logic [esp_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  localparam longint CNT_MASK   = 65535;
  localparam longint REV_COUNTS = 1216;
  localparam longint ERR_MAX    = 32767;
  localparam longint ERR_MIN    = -32768;
  localparam longint I32_MAX    = 64'sd2147483647;
  localparam longint I32_MIN    = -64'sd2147483648;

  typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_LONG} rx_mode_t;

  typedef struct packed {
    esp_pkg::esp_in_t  tick;
    logic              known;
    esp_pkg::esp_out_t result;
  } tick_row_t;

  logic                           clk       = 1'b0;
  logic                           rst_n     = 1'b0;
  logic                           in_valid  = 1'b0;
  logic                           in_stall;
  esp_pkg::esp_in_t               in_data   = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  esp_pkg::esp_out_t              out_data;
  logic                           cfg_we    = 1'b0;
  logic [esp_pkg::CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [esp_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  // register and state copy of the controller
  logic [15:0] kp        = esp_pkg::RST_GAIN_PROP;
  logic [15:0] ki        = esp_pkg::RST_GAIN_INTEGRAL;
  logic [15:0] kd        = esp_pkg::RST_GAIN_DERIV;
  logic [15:0] spd_limit = esp_pkg::RST_SPEED_LIMIT;
  logic [15:0] settle    = esp_pkg::RST_SETTLE_SPEED;
  logic [9:0]  dband     = esp_pkg::RST_DEADBAND;
  logic [6:0]  cmd_max   = esp_pkg::RST_OUTPUT_MAX;
  longint      integ_acc = 0;
  longint      err_prev  = 0;

  esp_pkg::esp_out_t due_commands[$];
  tick_row_t         dir_rows [N_DIR];

  int ticks_sent   = 0;
  int results_seen = 0;
  int holds_seen   = 0;
  int errors       = 0;
  int settings_run = 0;
  int idle_cycles  = 0;

  rx_mode_t stall_mode = RX_OPEN;
  int       stall_left = 0;

  encoder_speed_pid_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always #HALF_PERIOD clk = ~clk;

  function automatic longint sat(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // rpm before the overspeed check, encoder wrap formula as specified
  function automatic longint raw_rpm(input esp_pkg::esp_in_t t);
    longint now_c, prev_c, delta, ms;
    now_c  = t.count_now;
    prev_c = t.count_before;
    ms     = (t.elapsed_ms == 0) ? 1 : t.elapsed_ms;
    if (t.counting_down) begin
      delta = (now_c < prev_c) ? prev_c - now_c : (CNT_MASK - now_c) + prev_c;
    end else begin
      delta = (now_c > prev_c) ? now_c - prev_c : (CNT_MASK - prev_c) + now_c;
    end
    delta = delta & CNT_MASK;
    return ((delta * 60) / REV_COUNTS) * (1000 / ms);
  endfunction

  // one control tick; updates integ_acc / err_prev unless the hold applies
  function automatic esp_pkg::esp_out_t next_command(input esp_pkg::esp_in_t t);
    esp_pkg::esp_out_t r;
    longint   rpm, goal, err, ms, p, d, i, sum, mag, cmd;
    longint   gp, gi, gd, lim, settle_v, db, cmax;
    gp       = kp;
    gi       = ki;
    gd       = kd;
    lim      = spd_limit;
    settle_v = settle;
    db       = dband;
    cmax     = cmd_max;
    ms       = (t.elapsed_ms == 0) ? 1 : t.elapsed_ms;
    rpm      = raw_rpm(t);
    if (rpm > lim) rpm = 0;
    goal = (longint'(t.target_speed) * 9) / 2;
    err  = sat(goal - rpm, ERR_MIN, ERR_MAX);
    r.measured_speed = 16'(rpm);
    mag = (err < 0) ? -err : err;
    if (rpm > settle_v && mag < db) begin
      r.drive_command = t.last_command;
      r.held          = 1'b1;
      return r;
    end
    p = gp * err;
    d = (gd * (err - err_prev)) / ms;
    i = sat(integ_acc + gi * err, I32_MIN, I32_MAX);
    integ_acc = i;
    err_prev  = err;
    sum = p + d + i;
    mag = (sum < 0) ? -sum : sum;
    cmd = ((mag * 2) / 9) / 256;
    if (cmd > cmax) cmd = cmax;
    r.drive_command = 7'(cmd);
    r.held          = 1'b0;
    return r;
  endfunction

  function automatic tick_row_t row(input logic [15:0] now_c, prev_c, input logic dn,
                                    input logic [15:0] ms, input logic [7:0] tgt,
                                    input logic [6:0] last, input logic known,
                                    input logic [6:0] cmd, input logic [15:0] spd,
                                    input logic hld);
    tick_row_t x;
    x.tick.count_now            = now_c;
    x.tick.count_before         = prev_c;
    x.tick.counting_down        = dn;
    x.tick.elapsed_ms           = ms;
    x.tick.target_speed         = tgt;
    x.tick.last_command         = last;
    x.known                     = known;
    x.result.drive_command      = cmd;
    x.result.measured_speed     = spd;
    x.result.held               = hld;
    return x;
  endfunction

  // mostly plausible ticks (small delta, short interval), some fully random
  function automatic esp_pkg::esp_in_t random_tick();
    esp_pkg::esp_in_t t;
    int unsigned      kind;
    logic [15:0]      delta;
    longint           goal;
    t    = esp_pkg::esp_in_t'({$urandom, $urandom});
    kind = $urandom_range(0, 9);
    if (kind < 3) begin
      if ($urandom_range(0, 5) == 0) t.elapsed_ms = '0;
    end else begin
      t.elapsed_ms = 16'($urandom_range(1, 30));
      delta        = 16'($urandom_range(0, 700));
      t.count_now  = t.counting_down ? t.count_before - delta : t.count_before + delta;
      if (kind >= 7) begin
        // aim the target at the measured speed to land near the deadband
        goal = (raw_rpm(t) * 2) / 9 + $urandom_range(0, 4) - 2;
        t.target_speed = 8'(sat(goal, 0, 255));
      end
    end
    return t;
  endfunction

  task automatic send_tick(input esp_pkg::esp_in_t t, input logic known,
                           input esp_pkg::esp_out_t typed);
    esp_pkg::esp_out_t pred;
    in_valid <= 1'b1;
    in_data  <= t;
    do @(posedge clk); while (in_stall);
    pred = next_command(t);
    due_commands.push_back(known ? typed : pred);
    ticks_sent++;
  endtask

  task automatic drain();
    while (due_commands.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [esp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [esp_pkg::CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      esp_pkg::REG_GAIN_PROP:     kp        = val;
      esp_pkg::REG_GAIN_INTEGRAL: ki        = val;
      esp_pkg::REG_GAIN_DERIV:    kd        = val;
      esp_pkg::REG_SPEED_LIMIT:   spd_limit = val;
      esp_pkg::REG_SETTLE_SPEED:  settle    = val;
      esp_pkg::REG_DEADBAND:      dband     = val[9:0];
      esp_pkg::REG_OUTPUT_MAX:    cmd_max   = val[6:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(input int s);
    logic [15:0] v;
    if (s == N_SETTINGS - 1) begin
      write_reg(esp_pkg::REG_GAIN_PROP,     esp_pkg::RST_GAIN_PROP);
      write_reg(esp_pkg::REG_GAIN_INTEGRAL, esp_pkg::RST_GAIN_INTEGRAL);
      write_reg(esp_pkg::REG_GAIN_DERIV,    esp_pkg::RST_GAIN_DERIV);
      write_reg(esp_pkg::REG_SPEED_LIMIT,   esp_pkg::RST_SPEED_LIMIT);
      write_reg(esp_pkg::REG_SETTLE_SPEED,  esp_pkg::RST_SETTLE_SPEED);
      write_reg(esp_pkg::REG_DEADBAND,      16'(esp_pkg::RST_DEADBAND));
      write_reg(esp_pkg::REG_OUTPUT_MAX,    16'(esp_pkg::RST_OUTPUT_MAX));
    end else begin
      for (int r = int'(esp_pkg::REG_GAIN_PROP); r <= int'(esp_pkg::REG_OUTPUT_MAX); r++) begin
        case (s)
          1: v = '0;
          2: v = '1;
          default: begin
            case ($urandom_range(0, 4))
              0: v = '0;
              1: v = '1;
              2: v = 16'($urandom_range(0, 2047));
              default: v = 16'($urandom);
            endcase
          end
        endcase
        write_reg(esp_pkg::CFG_IDX_W'(r), v);
      end
      // a write to the spare index must change nothing
      write_reg(REG_UNUSED, 16'($urandom));
    end
    cfg_we <= 1'b0;
  endtask

  // receiver: stretches of open, light, heavy and long periodic stalls
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= rx_mode_t'($urandom_range(0, 3));
      stall_left <= $urandom_range(10, 300);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      RX_OPEN:  out_stall <= 1'b0;
      RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      RX_HEAVY: out_stall <= ($urandom_range(0, 1) == 0);
      default:  out_stall <= ((stall_left % 32) < 20);
    endcase
  end

  always @(posedge clk) begin : check_results
    esp_pkg::esp_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (out_data.held) holds_seen++;
      if (due_commands.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing due, got %p", $time, out_data);
      end else begin
        want = due_commands.pop_front();
        if (out_data.drive_command !== want.drive_command) begin
          errors++;
          $display("%0t: drive_command expected %0d got %0d", $time,
                   want.drive_command, out_data.drive_command);
        end
        if (out_data.measured_speed !== want.measured_speed) begin
          errors++;
          $display("%0t: measured_speed expected %0d got %0d", $time,
                   want.measured_speed, out_data.measured_speed);
        end
        if (out_data.held !== want.held) begin
          errors++;
          $display("%0t: held expected %0b got %0b", $time, want.held, out_data.held);
        end
      end
    end
  end

  // counts cycles with no beat on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, idle_cycles);
      $display("encoder_speed_pid_top verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int burst;
    int gap;
    dir_rows = '{
      row(16'd100,   16'd100,   1'b0, 16'd1,     8'd0,   7'd0,   1'b1, 7'd0,   16'd0,   1'b0),
      row(16'd100,   16'd100,   1'b0, 16'd1,     8'd255, 7'd0,   1'b1, 7'd127, 16'd0,   1'b0),
      row(16'd1070,  16'd1000,  1'b0, 16'd10,    8'd67,  7'd93,  1'b1, 7'd93,  16'd300, 1'b1),
      row(16'd1070,  16'd1000,  1'b0, 16'd10,    8'd68,  7'd127, 1'b1, 7'd127, 16'd300, 1'b1),
      row(16'd5000,  16'd5000,  1'b1, 16'd65535, 8'd0,   7'd0,   1'b0, 7'd0,   16'd0,   1'b0),
      row(16'd2000,  16'd0,     1'b0, 16'd0,     8'd100, 7'd64,  1'b0, 7'd0,   16'd0,   1'b0),
      row(16'd65535, 16'd0,     1'b0, 16'd1000,  8'd255, 7'd127, 1'b0, 7'd0,   16'd0,   1'b0),
      row(16'd0,     16'd65535, 1'b1, 16'd1000,  8'd0,   7'd1,   1'b0, 7'd0,   16'd0,   1'b0),
      row(16'd65535, 16'd65535, 1'b1, 16'd1,     8'd128, 7'd2,   1'b0, 7'd0,   16'd0,   1'b0),
      row(16'd0,     16'd0,     1'b0, 16'd7,     8'd10,  7'd3,   1'b0, 7'd0,   16'd0,   1'b0),
      row(16'd900,   16'd1000,  1'b1, 16'd20,    8'd44,  7'd20,  1'b0, 7'd0,   16'd0,   1'b0),
      row(16'd10,    16'd65500, 1'b0, 16'd5,     8'd89,  7'd55,  1'b1, 7'd55,  16'd400, 1'b1),
      row(16'd65530, 16'd20,    1'b1, 16'd4,     8'd56,  7'd100, 1'b0, 7'd0,   16'd0,   1'b0),
      row(16'd30,    16'd0,     1'b0, 16'd2,     8'd0,   7'd0,   1'b0, 7'd0,   16'd0,   1'b0),
      row(16'd130,   16'd0,     1'b0, 16'd10,    8'd255, 7'd127, 1'b0, 7'd0,   16'd0,   1'b0),
      row(16'd230,   16'd0,     1'b0, 16'd20,    8'd122, 7'd77,  1'b1, 7'd77,  16'd550, 1'b1),
      row(16'hAAAA,  16'h5555,  1'b1, 16'h5555,  8'hAA,  7'h55,  1'b0, 7'd0,   16'd0,   1'b0),
      row(16'h5555,  16'hAAAA,  1'b0, 16'hAAAA,  8'h55,  7'h2A,  1'b0, 7'd0,   16'd0,   1'b0),
      row(16'd1,     16'd0,     1'b1, 16'd300,   8'd255, 7'd127, 1'b0, 7'd0,   16'd0,   1'b0),
      row(16'd0,     16'd0,     1'b1, 16'd65535, 8'd255, 7'd127, 1'b0, 7'd0,   16'd0,   1'b0),
      row(16'd64,    16'd0,     1'b0, 16'd8,     8'd255, 7'd0,   1'b0, 7'd0,   16'd0,   1'b0)
    };
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int k = 0; k < N_DIR; k++) begin
      send_tick(dir_rows[k].tick, dir_rows[k].known, dir_rows[k].result);
    end

    for (int s = 0; s < N_SETTINGS; s++) begin
      // registers only change once every result is out
      in_valid <= 1'b0;
      drain();
      if (s > 0) apply_setting(s);
      settings_run++;
      burst = $urandom_range(1, 16);
      for (int n = 0; n < TICKS_PER_SETTING; n++) begin
        send_tick(random_tick(), 1'b0, '0);
        burst--;
        if (burst == 0) begin
          burst = $urandom_range(1, 16);
          case ($urandom_range(0, 7))
            0, 1:    gap = 0;
            7:       gap = $urandom_range(100, 250);
            default: gap = $urandom_range(1, 40);
          endcase
          if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
          end
        end
      end
    end

    in_valid <= 1'b0;
    drain();
    repeat (4 * SETTLE_CYCLES) @(posedge clk);

    $display("Ran %0d ticks under %0d register settings; %0d result beats compared, %0d held.",
             ticks_sent, settings_run, results_seen, holds_seen);
    $display("Field mismatches and stray beats: %0d", errors);
    if (errors == 0) begin
      $display("encoder_speed_pid_top verification clean");
    end else begin
      $display("encoder_speed_pid_top verification failed");
    end
    $finish;
  end

endmodule
